// ----- rtl/idle_timeout_frame_receiver_macros.svh -----
// assertion macros used by the checker file
`ifndef IDLE_TIMEOUT_FRAME_RECEIVER_MACROS_SVH
`define IDLE_TIMEOUT_FRAME_RECEIVER_MACROS_SVH

// property that holds in and out of reset
`define IFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// property that is checked only outside reset
`define IFR_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ----- rtl/ifr_pkg.sv -----
package ifr_pkg;

  // default receive and ready buffer depth
  localparam int unsigned BUFFER_DEPTH_DEF = 64;

  // operation codes
  localparam logic [2:0] OP_BYTE  = 3'd0;
  localparam logic [2:0] OP_TICK  = 3'd1;
  localparam logic [2:0] OP_CLRF  = 3'd2;
  localparam logic [2:0] OP_ZERO  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // configuration register indexes
  localparam logic CFG_TIMEOUT_RELOAD = 1'b0;
  localparam logic CFG_TICK_PERIOD    = 1'b1;

  // configuration reset values
  localparam logic [15:0] RELOAD_RST = 16'd20;
  localparam logic [15:0] PERIOD_RST = 16'd1;

  // input item
  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } in_item_t;

  // result item
  typedef struct packed {
    logic       ready_flag;
    logic [6:0] ready_length;
    logic [7:0] read_data;
    logic       frame_done;
  } out_item_t;

  // memory port controls
  typedef struct packed {
    logic we;
    logic re;
  } ram_cmd_t;

endpackage

// ----- rtl/ifr_ram.sv -----
module ifr_ram
  import ifr_pkg::*;
#(
  parameter int unsigned Depth = BUFFER_DEPTH_DEF,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  ram_cmd_t         cmd_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (cmd_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/idle_timeout_frame_receiver.sv -----
// Idle-timeout frame receiver. Bytes go into a receive memory; every byte
// reloads the timeout counter, and a tick that lowers the counter below the
// tick period closes the frame and copies it into the ready memory. An item
// is taken when start is high and busy is low, and its result shows on out_o
// for one cycle with result_valid_o; the receiver cannot stall, so the result
// must be taken in that cycle. A tick that completes a frame runs a copy loop
// that moves one entry per cycle through the registered read port of the
// receive memory into the ready memory. Zeroing the ready memory writes one
// entry per cycle. After reset a clearing pass zeroes the ready memory while
// busy stays high; configuration writes are taken at any time and apply when
// the block is idle.
module idle_timeout_frame_receiver
  import ifr_pkg::*;
#(
  parameter int unsigned BufferDepth = BUFFER_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item_i,
  output logic      result_valid_o,
  output out_item_t out_o,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IdxW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
  localparam int unsigned LenW = $clog2(BufferDepth + 1);

  // sequencer states
  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RESP  = 3'd2;
  localparam logic [2:0] S_COPY  = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] wr_q, wr_d;
  logic [LenW-1:0] len_q, len_d;
  logic [15:0]     tmo_q, tmo_d;
  logic            flag_q, flag_d;
  logic            done_q, done_d;
  logic            rsel_q, rsel_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] paddr_q, paddr_d;
  logic [15:0]     reload_q, period_q;

  logic            accept;
  logic [LenW-1:0] wr_eff;
  logic [15:0]     tmo_diff;
  logic            rd_in_range;

  ram_cmd_t        rx_cmd, rdy_cmd;
  logic [IdxW-1:0] rx_waddr, rx_raddr, rdy_waddr, rdy_raddr;
  logic [7:0]      rx_wdata, rx_rdata, rdy_wdata, rdy_rdata;

  assign accept      = start && (state_q == S_IDLE);
  assign busy        = (state_q != S_IDLE);
  assign wr_eff      = (wr_q == LenW'(BufferDepth)) ? '0 : wr_q;
  assign tmo_diff    = tmo_q - period_q;
  assign rd_in_range = int'(in_item_i.read_index) < int'(BufferDepth);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= RELOAD_RST;
      period_q <= PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIMEOUT_RELOAD: reload_q <= cfg_data_i;
        CFG_TICK_PERIOD:    period_q <= cfg_data_i;
        default:            reload_q <= reload_q;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    wr_d    = wr_q;
    len_d   = len_q;
    tmo_d   = tmo_q;
    flag_d  = flag_q;
    done_d  = done_q;
    rsel_d  = rsel_q;
    pend_d  = 1'b0;
    paddr_d = paddr_q;
    case (state_q)
      S_INIT, S_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LenW'(BufferDepth - 1)) begin
          cnt_d   = '0;
          state_d = (state_q == S_INIT) ? S_IDLE : S_RESP;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_RESP;
          done_d  = 1'b0;
          rsel_d  = 1'b0;
          case (in_item_i.operation)
            OP_BYTE: begin
              tmo_d = reload_q;
              wr_d  = wr_eff + 1'b1;
            end
            OP_TICK: begin
              if (tmo_q >= period_q) begin
                tmo_d = tmo_diff;
                if (tmo_diff < period_q) begin
                  // idle time elapsed: close the frame
                  len_d   = wr_q;
                  wr_d    = '0;
                  tmo_d   = '0;
                  flag_d  = 1'b1;
                  done_d  = 1'b1;
                  cnt_d   = '0;
                  state_d = S_COPY;
                end
              end
            end
            OP_CLRF: flag_d = 1'b0;
            OP_ZERO: begin
              cnt_d   = '0;
              state_d = S_CLEAR;
            end
            OP_READ: rsel_d = rd_in_range;
            default: state_d = S_RESP;
          endcase
        end
      end
      S_COPY: begin
        // read entry cnt now, write it to the ready memory next cycle
        if (cnt_q < len_q) begin
          pend_d  = 1'b1;
          paddr_d = cnt_q[IdxW-1:0];
          cnt_d   = cnt_q + 1'b1;
        end else begin
          cnt_d   = '0;
          state_d = S_RESP;
        end
      end
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
      wr_q    <= '0;
      len_q   <= '0;
      tmo_q   <= '0;
      flag_q  <= 1'b0;
      done_q  <= 1'b0;
      rsel_q  <= 1'b0;
      pend_q  <= 1'b0;
      paddr_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wr_q    <= wr_d;
      len_q   <= len_d;
      tmo_q   <= tmo_d;
      flag_q  <= flag_d;
      done_q  <= done_d;
      rsel_q  <= rsel_d;
      pend_q  <= pend_d;
      paddr_q <= paddr_d;
    end
  end

  // receive memory port
  always_comb begin
    rx_cmd.we = accept && (in_item_i.operation == OP_BYTE);
    rx_cmd.re = (state_q == S_COPY) && (cnt_q < len_q);
    rx_waddr  = IdxW'(wr_eff);
    rx_wdata  = in_item_i.rx_byte;
    rx_raddr  = cnt_q[IdxW-1:0];
  end

  // ready memory port: clearing pass or copy write, item read
  always_comb begin
    rdy_cmd.we = (state_q == S_INIT) || (state_q == S_CLEAR) ||
                 ((state_q == S_COPY) && pend_q);
    rdy_cmd.re = accept && (in_item_i.operation == OP_READ) && rd_in_range;
    rdy_waddr  = (state_q == S_COPY) ? paddr_q : cnt_q[IdxW-1:0];
    rdy_wdata  = (state_q == S_COPY) ? rx_rdata : 8'h00;
    rdy_raddr  = IdxW'(in_item_i.read_index);
  end

  ifr_ram #(
    .Depth (BufferDepth)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .cmd_i   (rx_cmd),
    .waddr_i (rx_waddr),
    .wdata_i (rx_wdata),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  ifr_ram #(
    .Depth (BufferDepth)
  ) u_ready_ram (
    .clk_i   (clk_i),
    .cmd_i   (rdy_cmd),
    .waddr_i (rdy_waddr),
    .wdata_i (rdy_wdata),
    .raddr_i (rdy_raddr),
    .rdata_o (rdy_rdata)
  );

  // result item
  assign result_valid_o     = (state_q == S_RESP);
  assign out_o.ready_flag   = flag_q;
  assign out_o.ready_length = 7'(len_q);
  assign out_o.read_data    = rsel_q ? rdy_rdata : 8'h00;
  assign out_o.frame_done   = done_q;

endmodule

// ----- rtl/ifr_checker.sv -----
`include "idle_timeout_frame_receiver_macros.svh"

module ifr_checker
  import ifr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input out_item_t   out_o
);

  // a result only shows while an item is in work
  `IFR_ASSERT_ALWAYS(a_result_while_busy, clk_i, result_valid_o |-> busy, "result while idle")

  // an accepted item keeps the block busy in the next cycle
  `IFR_ASSERT_RUN(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "accept not busy")

  // one result per item, strobe lasts one cycle
  `IFR_ASSERT_RUN(a_single_strobe, clk_i, rst_ni, result_valid_o |=> !result_valid_o, "strobe held")

  // a completed frame always raises the ready flag
  `IFR_ASSERT_ALWAYS(a_done_flag, clk_i, out_o.frame_done |-> out_o.ready_flag, "done without flag")

endmodule

bind idle_timeout_frame_receiver ifr_checker u_ifr_checker (.*);
